FILE: hw/rtl/pursr_pkg.sv
// Shared constants, codes and types for the point-update range-sum block.
package pursr_pkg;

  localparam int unsigned DEPTH   = 4096;
  localparam int unsigned DataW   = 32;
  localparam int unsigned FirstW  = 13;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned AddrW   = $clog2(DEPTH);
  // Tree positions reach 2*DEPTH while stepping up, hence the extra bit.
  localparam int unsigned PosW    = $clog2(DEPTH + 1) + 1;
  localparam int unsigned InDataW = ((FirstW + DataW + 7) / 8) * 8;

  localparam logic [DataW-1:0] DEPTH_W = DataW'(DEPTH);

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SUB   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_POS_ERR   = 2'd1,
    STAT_ORDER_ERR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_QRY_RD,
    S_QRY_ACC,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] sum;
    status_e          status;
  } res_t;

endpackage

FILE: hw/rtl/pursr_ram.sv
// Single-port synchronous RAM with registered read.
module pursr_ram #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned Depth     = 4096,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic [DataWidth-1:0] wdata_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

FILE: hw/rtl/pursr_ctrl.sv
// Command sequencer: clear sweep, tree update walk and two-path prefix query.
module pursr_ctrl import pursr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  cmd_e                    in_cmd_i,
  input  logic [FirstW-1:0]       in_first_i,
  input  logic signed [DataW-1:0] in_second_i,
  output mem_req_t                mem_req_o,
  input  logic [DataW-1:0]        mem_rdata_i,
  output res_t                    res_o,
  input  logic                    res_ready_i
);

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  left_q, left_d;
  logic [DataW-1:0] delta_q, delta_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic             phase_q, phase_d;
  logic [DataW-1:0] sum_q, sum_d;
  status_e          status_q, status_d;

  logic [DataW-1:0] first_u, second_u;
  logic             first_ok, second_ok;
  logic [PosW-1:0]  pos_m1, lowbit, pos_up, pos_dn;
  logic [DataW-1:0] acc_nx;

  assign first_u   = DataW'(in_first_i);
  assign second_u  = $unsigned(in_second_i);
  assign first_ok  = (first_u != '0) && (first_u <= DEPTH_W);
  assign second_ok = (second_u != '0) && (second_u <= DEPTH_W);

  assign pos_m1 = pos_q - PosW'(1);
  assign lowbit = pos_q & (~pos_q + PosW'(1));
  assign pos_up = pos_q + lowbit;
  assign pos_dn = pos_q - lowbit;
  // right prefix adds, left prefix subtracts
  assign acc_nx = phase_q ? (acc_q - mem_rdata_i) : (acc_q + mem_rdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    left_q   <= left_d;
    delta_q  <= delta_d;
    acc_q    <= acc_d;
    phase_q  <= phase_d;
    sum_q    <= sum_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    pos_d      = pos_q;
    left_d     = left_q;
    delta_d    = delta_q;
    acc_d      = acc_q;
    phase_d    = phase_q;
    sum_d      = sum_q;
    status_d   = status_q;
    in_ready_o = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.addr  = pos_m1[AddrW-1:0];
    mem_req_o.wdata = mem_rdata_i + delta_q;
    res_o.valid  = 1'b0;
    res_o.sum    = sum_q;
    res_o.status = status_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_addr_q;
        mem_req_o.wdata = '0;
        clr_addr_d      = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(DEPTH - 1)) begin
          clr_addr_d = '0;
          state_d    = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sum_d    = '0;
          status_d = STAT_POS_ERR;
          unique case (in_cmd_i) inside
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_ADD, CMD_SUB: begin
              pos_d   = PosW'(in_first_i);
              delta_d = (in_cmd_i == CMD_ADD) ? second_u : (~second_u + DataW'(1));
              state_d = first_ok ? S_UPD_RD : S_RESULT;
            end
            CMD_QUERY: begin
              pos_d   = PosW'(second_u);
              left_d  = PosW'(in_first_i) - PosW'(1);
              acc_d   = '0;
              phase_d = 1'b0;
              if (!first_ok || !second_ok) begin
                state_d = S_RESULT;
              end else if (first_u > second_u) begin
                status_d = STAT_ORDER_ERR;
                state_d  = S_RESULT;
              end else begin
                state_d = S_QRY_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_UPD_RD: state_d = S_UPD_WR;
      S_UPD_WR: begin
        mem_req_o.we = 1'b1;
        pos_d        = pos_up;
        state_d      = (pos_up > PosW'(DEPTH)) ? S_IDLE : S_UPD_RD;
      end
      S_QRY_RD: state_d = S_QRY_ACC;
      S_QRY_ACC: begin
        acc_d = acc_nx;
        if (pos_dn != '0) begin
          pos_d   = pos_dn;
          state_d = S_QRY_RD;
        end else if (!phase_q && (left_q != '0)) begin
          phase_d = 1'b1;
          pos_d   = left_q;
          state_d = S_QRY_RD;
        end else begin
          sum_d    = acc_nx;
          status_d = STAT_OK;
          state_d  = S_RESULT;
        end
      end
      S_RESULT: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (mem_req_o.we && (mem_req_o.wdata == '0)))
    else $error("clear sweep not writing zero");

  a_walk_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD_RD || state_q == S_UPD_WR || state_q == S_QRY_RD ||
     state_q == S_QRY_ACC) |-> ((pos_q != '0) && (pos_q <= PosW'(DEPTH))))
    else $error("tree walk position out of range");

  a_acc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QRY_ACC) |-> ($past(state_q) == S_QRY_RD))
    else $error("accumulate without preceding read");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD_WR) |-> ($past(state_q) == S_UPD_RD))
    else $error("update write without preceding read");

  a_err_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status != STAT_OK)) |-> (res_o.sum == '0))
    else $error("error result with non-zero sum");

endmodule

FILE: hw/rtl/point_update_range_sum.sv
// Top level of the point-update range-sum block: stream ports, tree memory, result register.
//
//  channel  | direction | payload (low bit first)                  | transfer when
//  s_axis   | in        | tuser: command; tdata: first_position,    | tvalid & tready
//           |           |   second_operand, 3 zero pad bits          |
//  m_axis   | out       | tuser: status; tdata: range_sum          | tvalid & tready
//
// Each tree step is a read of the memory port, then the add and write-back
// (update) or accumulate (query). An update walks up to log2(DEPTH)+1 entries;
// a query walks two prefix paths. Error cases go straight to the result state.
// After reset, and after every clear command, a sweep writes zero to all DEPTH
// entries, one a cycle; no transfer is taken in the meantime. A finished result
// sits in the output register while the next command is taken.
module point_update_range_sum import pursr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,  // first_position, second_operand, pad
  input  logic [CmdW-1:0]    s_axis_tuser_i,  // command
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [DataW-1:0]   m_axis_tdata_o,  // range_sum
  output logic [StatW-1:0]   m_axis_tuser_o   // status
);

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;
  res_t             res;
  logic             res_ready;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_sum_q;
  status_e          out_status_q;

  pursr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (cmd_e'(s_axis_tuser_i)),
    .in_first_i  (s_axis_tdata_i[FirstW-1:0]),
    .in_second_i ($signed(s_axis_tdata_i[FirstW+DataW-1:FirstW])),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  pursr_ram #(
    .DataWidth (DataW),
    .Depth     (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: loads when empty or when its contents leave this cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_sum_q    <= res.sum;
      out_status_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sum_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

FILE: tb/sv/tb_point_update_range_sum.sv
// Self-checking testbench for the point-update range-sum block: directed table, then random traffic.
module tb_point_update_range_sum;
  import pursr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems  = 500;
  localparam int unsigned IdleLimit  = 20000;  // must outlast a whole clear sweep, which takes no transfer
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned FirstMax   = (1 << FirstW) - 1;

  // One command on the input stream; known rows carry a hand-written result.
  typedef struct packed {
    cmd_e             cmd;
    logic [FirstW-1:0] first;
    logic [DataW-1:0]  second;
    logic              known;
    logic [DataW-1:0]  exp_sum;
    status_e           exp_stat;
  } cmd_row_t;

  typedef struct packed {
    logic [DataW-1:0] sum;
    status_e          status;
  } sum_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic [InDataW-1:0] in_data = '0;
  logic [CmdW-1:0]    in_user = CMD_CLEAR;
  logic               out_ready = 1'b0;
  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [DataW-1:0]   m_axis_tdata_o;
  logic [StatW-1:0]   m_axis_tuser_o;

  // Shadow copy of the tree, positions 1 to DEPTH.
  logic [DataW-1:0] fen_sums [1:DEPTH];
  sum_result_t      expected_sums [$];

  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_len      = 0;
  int unsigned n_clear      = 0;
  int unsigned n_update     = 0;
  int unsigned n_query      = 0;
  int unsigned n_err_stat   = 0;
  int unsigned n_checked    = 0;

  point_update_range_sum u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),   // first_position, second_operand, pad
    .s_axis_tuser_i  (in_user),   // command
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // range_sum
    .m_axis_tuser_o  (m_axis_tuser_o)   // status
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void fen_add(input int unsigned pos, input logic [DataW-1:0] delta);
    int unsigned p;
    p = pos;
    while (p >= 1 && p <= DEPTH) begin
      fen_sums[p] += delta;
      p += p & (~p + 1);
    end
  endfunction

  function automatic logic [DataW-1:0] fen_prefix(input int unsigned pos);
    int unsigned      p;
    logic [DataW-1:0] acc;
    p   = (pos > DEPTH) ? DEPTH : pos;
    acc = '0;
    while (p > 0) begin
      acc += fen_sums[p];
      p -= p & (~p + 1);
    end
    return acc;
  endfunction

  function automatic bit pos_ok(input int unsigned pos);
    return pos >= 1 && pos <= DEPTH;
  endfunction

  // Applies one command to the shadow tree; returns 1 when a result is due.
  function automatic bit range_sum_predict(input cmd_row_t row, output sum_result_t res);
    int unsigned lo;
    int unsigned hi;
    lo  = row.first;
    hi  = row.second;
    res = '{sum: '0, status: STAT_OK};
    case (row.cmd) inside
      CMD_CLEAR: begin
        for (int p = 1; p <= DEPTH; p++) fen_sums[p] = '0;
        return 1'b0;
      end
      CMD_ADD, CMD_SUB: begin
        if (!pos_ok(lo)) begin
          res.status = STAT_POS_ERR;
          return 1'b1;
        end
        // negation wraps, so subtracting the most negative delta adds it
        fen_add(lo, (row.cmd == CMD_ADD) ? row.second : (~row.second + DataW'(1)));
        return 1'b0;
      end
      default: begin
        // a negative right end reads as a huge unsigned value and fails here
        if (!pos_ok(lo) || !pos_ok(hi)) res.status = STAT_POS_ERR;
        else if (lo > hi)                res.status = STAT_ORDER_ERR;
        else                             res.sum = fen_prefix(hi) - fen_prefix(lo - 1);
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic note_failure(input string what, input sum_result_t exp,
                              input logic [DataW-1:0] got_sum, input logic [StatW-1:0] got_stat);
    fail_count++;
    if (fail_count <= MaxReports)
      $display("%0t MISMATCH (%s): expected sum %h status %0d, got sum %h status %0d",
               $realtime, what, exp.sum, exp.status, got_sum, got_stat);
  endtask

  always @(posedge clk_i) begin
    sum_result_t exp;
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      if (expected_sums.size() == 0) begin
        note_failure("unexpected result", '0, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        exp = expected_sums.pop_front();
        n_checked++;
        if (m_axis_tdata_o !== exp.sum || m_axis_tuser_o !== exp.status)
          note_failure("field", exp, m_axis_tdata_o, m_axis_tuser_o);
      end
    end
    if (rst_ni && ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: no transfer on either side for too long.
  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("%0t watchdog: no transfer for %0d cycles", $realtime, IdleLimit);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // Segments of random length: always ready, coin toss, one-in-four stall, long stall.
  initial begin
    int unsigned mode;
    int unsigned seg_len;
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 64);
      hold    = $urandom_range(10, 40);
      for (int c = 0; c < seg_len; c++) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (c % 4) != 0;
          default: out_ready <= c >= hold;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic drive_row(input cmd_row_t row);
    sum_result_t predicted;
    bit          has_result;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= InDataW'({row.second, row.first});
    in_user  <= row.cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
    has_result = range_sum_predict(row, predicted);
    if (row.known) predicted = '{sum: row.exp_sum, status: row.exp_stat};
    if (row.known || has_result) begin
      expected_sums.push_back(predicted);
      if (predicted.status != STAT_OK) n_err_stat++;
    end
    case (row.cmd)
      CMD_CLEAR: n_clear++;
      CMD_QUERY: n_query++;
      default:   n_update++;
    endcase
  endtask

  // Hold the sender off until every outstanding result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
  endtask

  // Half of the picks fall on a hot spot of low positions so that queries see non-zero sums.
  function automatic logic [FirstW-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return FirstW'($urandom_range(1, 16));
      7:             return FirstW'(DEPTH - $urandom_range(0, 3));
      8:             return FirstW'(1 << $urandom_range(0, AddrW));
      default:       return FirstW'($urandom_range(1, DEPTH));
    endcase
  endfunction

  initial begin
    cmd_row_t          dir_rows [$];
    cmd_row_t          row;
    logic [FirstW-1:0] a;
    logic [FirstW-1:0] b;

    for (int p = 1; p <= DEPTH; p++) fen_sums[p] = '0;

    // Directed table: reset contents, extreme positions and deltas, every error.
    dir_rows.push_back('{CMD_QUERY, 13'd1,    DEPTH_W,      1'b1, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_QUERY, 13'd1,    32'd1,        1'b1, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_ADD,   13'd0,    32'd5,        1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_ADD,   13'd4097, 32'd5,        1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_SUB,   13'h1FFF, 32'hFFFFFFFF, 1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_ADD,   13'd1,    32'h7FFFFFFF, 1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_ADD,   13'd4096, 32'h80000000, 1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_SUB,   13'd2,    32'h80000000, 1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_SUB,   13'd4095, 32'd1,        1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_ADD,   13'd2048, 32'hFFFFFFFF, 1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_ADD,   13'd1,    32'd1,        1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_QUERY, 13'd1,    DEPTH_W,      1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_QUERY, 13'd2,    32'd2,        1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_QUERY, 13'd1,    32'd1,        1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_QUERY, 13'd4096, DEPTH_W,      1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_QUERY, 13'd0,    32'd5,        1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_QUERY, 13'd5,    32'd0,        1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_QUERY, 13'd1,    32'd4097,     1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_QUERY, 13'd1,    32'h80000000, 1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_QUERY, 13'd1,    32'hFFFFFFFF, 1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_QUERY, 13'd10,   32'd9,        1'b1, 32'd0, STAT_ORDER_ERR});
    dir_rows.push_back('{CMD_QUERY, 13'd4096, 32'd1,        1'b1, 32'd0, STAT_ORDER_ERR});
    // position check wins over the order check
    dir_rows.push_back('{CMD_QUERY, 13'h1FFF, 32'd1,        1'b1, 32'd0, STAT_POS_ERR});
    dir_rows.push_back('{CMD_CLEAR, 13'd0,    32'd0,        1'b0, 32'd0, STAT_OK});
    dir_rows.push_back('{CMD_QUERY, 13'd1,    DEPTH_W,      1'b1, 32'd0, STAT_OK});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) drive_row(dir_rows[i]);
    wait_for_results();

    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems / 2) wait_for_results();
      row = '{cmd: CMD_QUERY, first: '0, second: '0, known: 1'b0, exp_sum: '0, exp_stat: STAT_OK};
      case ($urandom_range(0, 99)) inside
        [0:0]: row.cmd = CMD_CLEAR;
        [1:43]: begin
          row.cmd   = ($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_SUB;
          row.first = pick_pos();
          case ($urandom_range(0, 5))
            0:       row.second = 32'h80000000;
            1:       row.second = 32'h7FFFFFFF;
            2, 3:    row.second = DataW'($urandom_range(0, 20)) - 32'd10;
            default: row.second = $urandom();
          endcase
        end
        [44:87]: begin
          a = pick_pos();
          b = pick_pos();
          if (a > b) begin
            row.first  = b;
            row.second = DataW'(a);
          end else begin
            row.first  = a;
            row.second = DataW'(b);
          end
          if ($urandom_range(0, 7) == 0) row.first = 13'd1;
        end
        [88:93]: begin
          // noise across the whole field ranges
          row.cmd    = cmd_e'($urandom_range(CMD_ADD, CMD_QUERY));
          row.first  = FirstW'($urandom_range(0, FirstMax));
          row.second = $urandom();
        end
        default: begin
          case ($urandom_range(0, 3))
            0: begin
              row.first  = FirstW'($urandom_range(2, DEPTH));
              row.second = DataW'($urandom_range(1, row.first - 1));
            end
            1: begin
              row.first  = ($urandom_range(0, 1) != 0) ? 13'd0 : FirstW'(DEPTH + 1);
              row.second = DataW'($urandom_range(1, DEPTH));
            end
            2: begin
              row.first  = pick_pos();
              case ($urandom_range(0, 2))
                0:       row.second = '0;
                1:       row.second = DataW'(DEPTH + 1);
                default: row.second = $urandom() | 32'h80000000;
              endcase
            end
            default: begin
              row.cmd    = ($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_SUB;
              row.first  = ($urandom_range(0, 1) != 0) ? 13'd0
                                                      : FirstW'($urandom_range(DEPTH + 1, FirstMax));
              row.second = $urandom();
            end
          endcase
        end
      endcase
      drive_row(row);
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    while (expected_sums.size() != 0)
      note_failure("missing result", expected_sums.pop_front(), 'x, 'x);

    $display("Run covered %0d clears, %0d updates and %0d queries; %0d results checked,",
             n_clear, n_update, n_query, n_checked);
    $display("%0d of them error statuses, with bursty input and a stalling output.", n_err_stat);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pursr_pkg.sv
hw/rtl/pursr_ram.sv
hw/rtl/pursr_ctrl.sv
hw/rtl/point_update_range_sum.sv
tb/sv/tb_point_update_range_sum.sv
